>>> rtl/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

	// Table geometry. SLOTS must be a power of two: the home slot is the low
	// key bits and the probe address wraps by overflow.
	localparam int SLOTS      = 1024;
	localparam int SLOT_BITS  = $clog2(SLOTS);
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = $clog2(SLOTS + 1);

	typedef logic [SLOT_BITS-1:0]  slot_addr_t;
	typedef logic [KEY_BITS-1:0]   slot_key_t;
	typedef logic [COUNT_BITS-1:0] probe_cnt_t;

	// Access request from the sequencer to the slot store.
	typedef struct packed {
		logic       rd_en;
		slot_addr_t rd_addr;
		logic       wr_en;
		slot_addr_t wr_addr;
		logic       wr_used;
		slot_key_t  wr_key;
	} slot_req_t;

	// Status of the slot read in the previous cycle.
	typedef struct packed {
		logic used;
		logic match;
	} slot_stat_t;

endpackage

>>> rtl/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  --------------------------------------------------
// in       in_valid / in_ready  mode, key
// out      out_valid/out_ready  probe_count, slot_index, hit, placed, table_full
//
// An item is accepted in ST_IDLE, then probes one slot at a time in ST_PROBE,
// from 1 to SLOTS probes; in_ready is low until its run ends, so a new item waits.
// Probing is serial, set by the single read port of the slot store, read once per probe.
// After reset the store is swept slot by slot to clear the used bits;
// in_ready stays low during that sweep.
// A result waits in the output register; if it has not been taken when the next
// item ends its probe run, the sequencer holds on the last slot until it is.

module linear_probe_hash_table_core
	import lpht_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  slot_key_t  key,
	output logic       out_valid,
	input  logic       out_ready,
	output probe_cnt_t probe_count,
	output slot_addr_t slot_index,
	output logic       hit,
	output logic       placed,
	output logic       table_full
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_PROBE = 3'b100
	} state_t;

	state_t     state_q;
	slot_addr_t clr_q;
	slot_addr_t addr_q;
	probe_cnt_t cnt_q;
	slot_key_t  key_q;
	logic       lookup_q;

	logic       out_valid_q;
	probe_cnt_t probe_count_q;
	slot_addr_t slot_index_q;
	logic       hit_q;
	logic       placed_q;
	logic       full_q;

	slot_req_t  req;
	slot_stat_t stat;

	logic accept;
	logic probing;
	logic clearing;
	logic found;
	logic empty;
	logic last;
	logic stop;
	logic out_free;
	logic advance;
	logic finish;

	lpht_slot_store u_store (
		.clk       (clk),
		.req       (req),
		.probe_key (key_q),
		.stat      (stat)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign probing  = (state_q == ST_PROBE);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// The slot read last cycle sits at addr_q. A match ends the run, so does an
	// empty slot; after SLOTS probes with neither, the table is full.
	assign found    = stat.match;
	assign empty    = !stat.used;
	assign last     = (cnt_q == COUNT_BITS'(SLOTS));
	assign stop     = found || empty || last;
	assign out_free = !out_valid_q || out_ready;
	assign advance  = probing && !stop;
	assign finish   = probing && stop && out_free;

	// Reads go to the home slot on accept and to the next slot on each step.
	// An insert writes on its final cycle, before the next item can read.
	always_comb begin
		req.rd_en   = accept || advance;
		req.rd_addr = probing ? slot_addr_t'(addr_q + 1'b1) : key[SLOT_BITS-1:0];
		req.wr_en   = clearing || (finish && empty && !lookup_q);
		req.wr_addr = clearing ? clr_q : addr_q;
		req.wr_used = !clearing;
		req.wr_key  = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == slot_addr_t'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Probe position and item payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= key[SLOT_BITS-1:0];
			cnt_q    <= probe_cnt_t'(1);
			key_q    <= key;
			lookup_q <= mode;
		end else if (advance) begin
			addr_q <= addr_q + 1'b1;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			probe_count_q <= cnt_q;
			slot_index_q  <= addr_q;
			hit_q         <= found;
			placed_q      <= empty && !lookup_q;
			full_q        <= !found && !empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign probe_count = probe_count_q;
	assign slot_index  = slot_index_q;
	assign hit         = hit_q;
	assign placed      = placed_q;
	assign table_full  = full_q;

endmodule

>>> rtl/lpht_slot_store.sv
`timescale 1ns / 1ps

module lpht_slot_store
	import lpht_pkg::*;
(
	input  logic       clk,
	input  slot_req_t  req,
	input  slot_key_t  probe_key,
	output slot_stat_t stat
);

	// Each entry holds the used bit above the stored key.
	logic [KEY_BITS:0] mem [SLOTS];
	logic [KEY_BITS:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= {req.wr_used, req.wr_key};
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	// The single key comparator, reused on every probe.
	assign stat.used  = rdata_q[KEY_BITS];
	assign stat.match = rdata_q[KEY_BITS] && (rdata_q[KEY_BITS-1:0] == probe_key);

endmodule
